[sv/lms_pkg.sv]
// Shared constants and controller/datapath interface types for the LPT machine scheduler.
// This package has no dependencies. Every other file refers to it by scoped names.
package lms_pkg;

	localparam int MAX_JOBS     = 64;
	localparam int MAX_MACHINES = 8;
	localparam int JOB_AW       = $clog2(MAX_JOBS);
	localparam int CNT_W        = $clog2(MAX_JOBS + 1);
	localparam int MACH_W       = 3;
	localparam int MCFG_W       = 4;
	localparam int ID_W         = 8;
	localparam int JT_W         = 16;
	localparam int TIME_W       = 22;

	localparam logic [TIME_W-1:0] TIME_MAX   = '1;
	localparam logic [MCFG_W-1:0] MACH_RESET = MCFG_W'(3);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // store the input beat (if there is room)
		logic scan_init;    // restart a pass over the job store
		logic scan_issue;   // read the next stored job and test the next machine
		logic pick;         // read the winning job's id and mark it used
		logic emit_job;     // register one assignment result
		logic emit_status;  // register the single status result
		logic clear_batch;  // forget the batch and idle all machines
	} lms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fits;         // machines in use cover every loaded job
		logic scan_last;    // the read being issued is the last stored job
		logic final_job;    // the job being emitted is the last of the batch
	} lms_stat_t;

endpackage

[sv/lms_datapath.sv]
// Datapath of the LPT machine scheduler: job store, scan compare, machine free times.
// Depends on lms_pkg. Driven by lms_ctrl through lms_pkg::lms_cmd_t.
module lms_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lms_pkg::lms_cmd_t             cmd,
	output lms_pkg::lms_stat_t            stat,
	input  logic                          cfg_write,
	input  logic [lms_pkg::MCFG_W-1:0]    cfg_data,
	input  logic [lms_pkg::ID_W-1:0]      job_id,
	input  logic [lms_pkg::JT_W-1:0]      job_time,
	output logic                          result_valid,
	output logic                          status,
	output logic [lms_pkg::ID_W-1:0]      assigned_job,
	output logic [lms_pkg::MACH_W-1:0]    machine_index,
	output logic [lms_pkg::TIME_W-1:0]    start_time,
	output logic [lms_pkg::TIME_W-1:0]    end_time,
	output logic                          last_result
);

	logic [lms_pkg::ID_W-1:0]   id_mem   [lms_pkg::MAX_JOBS];
	logic [lms_pkg::JT_W-1:0]   time_mem [lms_pkg::MAX_JOBS];

	logic [lms_pkg::MCFG_W-1:0] cfg_q;
	logic [lms_pkg::MCFG_W-1:0] m_sat;
	logic [lms_pkg::CNT_W-1:0]  loaded_q;
	logic [lms_pkg::CNT_W-1:0]  k_q;
	logic [lms_pkg::CNT_W-1:0]  pos_q;
	logic [lms_pkg::MAX_JOBS-1:0] used_q;
	logic [lms_pkg::TIME_W-1:0] free_q [lms_pkg::MAX_MACHINES];

	logic                       full;
	logic                       rd_en;
	logic [lms_pkg::JOB_AW-1:0] rd_addr;
	logic [lms_pkg::ID_W-1:0]   rd_id_s1;
	logic [lms_pkg::JT_W-1:0]   rd_time_s1;
	logic [lms_pkg::JOB_AW-1:0] k_s1;
	logic                       valid_s1;

	logic                       have_best_q;
	logic [lms_pkg::JOB_AW-1:0] best_idx_q;
	logic [lms_pkg::JT_W-1:0]   best_time_q;
	logic [lms_pkg::MACH_W-1:0] min_idx_q;
	logic [lms_pkg::TIME_W-1:0] min_time_q;

	logic                       cand;
	logic                       mach_probe;
	logic [lms_pkg::MACH_W-1:0] mach_sel;
	logic                       mach_take;
	logic [lms_pkg::TIME_W:0]   end_sum;
	logic [lms_pkg::TIME_W-1:0] end_val;

	// Zero machines counts as one; more than exist saturates.
	always_comb begin
		if (cfg_q == '0) begin
			m_sat = lms_pkg::MCFG_W'(1);
		end else if (cfg_q > lms_pkg::MCFG_W'(lms_pkg::MAX_MACHINES)) begin
			m_sat = lms_pkg::MCFG_W'(lms_pkg::MAX_MACHINES);
		end else begin
			m_sat = cfg_q;
		end
	end

	assign full    = (loaded_q == lms_pkg::CNT_W'(lms_pkg::MAX_JOBS));
	assign rd_en   = cmd.scan_issue | cmd.pick;
	assign rd_addr = cmd.pick ? best_idx_q : k_q[lms_pkg::JOB_AW-1:0];

	assign stat.fits      = ({{(lms_pkg::CNT_W-lms_pkg::MCFG_W){1'b0}}, m_sat} >= loaded_q);
	assign stat.scan_last = ((k_q + lms_pkg::CNT_W'(1)) == loaded_q);
	assign stat.final_job = ((pos_q + lms_pkg::CNT_W'(1)) == loaded_q);

	// Strictly greater keeps the earliest arrival on equal times.
	assign cand = valid_s1 && !used_q[k_s1] && (!have_best_q || (rd_time_s1 > best_time_q));

	// Machine search rides along with the job scan; strictly less keeps the lowest index.
	assign mach_probe = cmd.scan_issue &&
		(k_q < {{(lms_pkg::CNT_W-lms_pkg::MCFG_W){1'b0}}, m_sat});
	assign mach_sel   = k_q[lms_pkg::MACH_W-1:0];
	assign mach_take  = mach_probe && ((k_q == '0) || (free_q[mach_sel] < min_time_q));

	assign end_sum = {1'b0, min_time_q} + {{(lms_pkg::TIME_W+1-lms_pkg::JT_W){1'b0}}, best_time_q};
	assign end_val = end_sum[lms_pkg::TIME_W] ? lms_pkg::TIME_MAX
		: end_sum[lms_pkg::TIME_W-1:0];

	// Job store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			id_mem[loaded_q[lms_pkg::JOB_AW-1:0]]   <= job_id;
			time_mem[loaded_q[lms_pkg::JOB_AW-1:0]] <= job_time;
		end
		if (rd_en) begin
			rd_id_s1   <= id_mem[rd_addr];
			rd_time_s1 <= time_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q[lms_pkg::JOB_AW-1:0];
		if (cand) begin
			best_idx_q  <= k_s1;
			best_time_q <= rd_time_s1;
		end
		if (mach_take) begin
			min_idx_q  <= mach_sel;
			min_time_q <= free_q[mach_sel];
		end
		if (cmd.emit_status) begin
			status        <= 1'b1;
			assigned_job  <= '0;
			machine_index <= '0;
			start_time    <= '0;
			end_time      <= '0;
			last_result   <= 1'b1;
		end else if (cmd.emit_job) begin
			status        <= 1'b0;
			assigned_job  <= rd_id_s1;
			machine_index <= min_idx_q;
			start_time    <= min_time_q;
			end_time      <= end_val;
			last_result   <= stat.final_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= lms_pkg::MACH_RESET;
			loaded_q     <= '0;
			k_q          <= '0;
			pos_q        <= '0;
			used_q       <= '0;
			valid_s1     <= 1'b0;
			have_best_q  <= 1'b0;
			result_valid <= 1'b0;
			for (int i = 0; i < lms_pkg::MAX_MACHINES; i++) begin
				free_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				cfg_q <= cfg_data;
			end
			valid_s1     <= cmd.scan_issue;
			result_valid <= cmd.emit_job | cmd.emit_status;
			if (cmd.scan_init) begin
				k_q         <= '0;
				have_best_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					k_q <= k_q + lms_pkg::CNT_W'(1);
				end
				if (cand) begin
					have_best_q <= 1'b1;
				end
			end
			// The final result of a batch also clears it, so the clear takes priority.
			if (cmd.clear_batch) begin
				loaded_q <= '0;
				pos_q    <= '0;
				used_q   <= '0;
				for (int i = 0; i < lms_pkg::MAX_MACHINES; i++) begin
					free_q[i] <= '0;
				end
			end else begin
				if (cmd.load && !full) begin
					loaded_q <= loaded_q + lms_pkg::CNT_W'(1);
				end
				if (cmd.pick) begin
					used_q[best_idx_q] <= 1'b1;
				end
				if (cmd.emit_job) begin
					free_q[min_idx_q] <= end_val;
					pos_q             <= pos_q + lms_pkg::CNT_W'(1);
				end
			end
		end
	end

	a_job_only_when_short: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_job |-> !stat.fits)
		else $error("assignment result emitted although machines cover all jobs");

	a_pick_has_winner: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |-> have_best_q)
		else $error("pick issued with no unused job found by the scan");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status) |-> last_result)
		else $error("status result not marked as last");

	a_batch_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |-> (loaded_q == '0 && pos_q == '0))
		else $error("batch state not cleared after final result");

endmodule

[sv/lms_ctrl.sv]
// Controller state machine of the LPT machine scheduler.
// Depends on lms_pkg. Sequences lms_datapath through lms_pkg::lms_cmd_t.
module lms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                last_job,
	input  lms_pkg::lms_stat_t  stat,
	output lms_pkg::lms_cmd_t   cmd,
	output logic                busy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_PICK   = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_job) begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				if (stat.fits) begin
					cmd.emit_status = 1'b1;
					cmd.clear_batch = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// The last read's compare lands in this cycle.
			ST_DRAIN: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_job = 1'b1;
				if (stat.final_job) begin
					cmd.clear_batch = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_job && cmd.emit_status))
		else $error("status and assignment results issued together");

	a_pick_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |-> $past(state_q) == ST_DRAIN)
		else $error("pick not preceded by the scan drain cycle");

	a_idle_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_batch |=> !busy)
		else $error("controller did not return to idle after clearing the batch");

endmodule

[sv/lpt_machine_scheduler_unit.sv]
// Top level of the LPT (longest processing time first) machine scheduler.
// Depends on lms_pkg, lms_ctrl and lms_datapath.

// Jobs are loaded one beat per clock while busy is low: a beat is taken at each rising edge with
// start high and busy low, and up to 64 jobs are stored (later ones are dropped, though a dropped
// beat carrying last_job still ends the batch). The beat with last_job set raises busy and starts
// scheduling. If the configured machine count (zero counts as one, above eight counts as eight)
// covers all n stored jobs, one status result follows, issued in the decide state. Otherwise the
// block makes one pass over the job store per result: each pass reads one stored job per cycle
// from the single read port of the job store, then the block waits for the last compare, reads
// the winning job and emits its assignment. The same pass walks the machine free times to find
// the machine that idles first, lowest index on a tie. Jobs come out longest first, equal times
// in arrival order. Results leave on result_valid for exactly one cycle each and cannot be held
// off by the receiver; the final result of a batch appears in the first cycle after busy falls,
// so a new batch can start loading while it is still on the ports. All machines restart at time
// zero for every batch. The machine count register is written with cfg_write and cfg_data and
// must only change while busy is low.
module lpt_machine_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [lms_pkg::ID_W-1:0]      job_id,
	input  logic [lms_pkg::JT_W-1:0]      job_time,
	input  logic                          last_job,
	input  logic                          cfg_write,
	input  logic [lms_pkg::MCFG_W-1:0]    cfg_data,
	output logic                          result_valid,
	output logic                          status,
	output logic [lms_pkg::ID_W-1:0]      assigned_job,
	output logic [lms_pkg::MACH_W-1:0]    machine_index,
	output logic [lms_pkg::TIME_W-1:0]    start_time,
	output logic [lms_pkg::TIME_W-1:0]    end_time,
	output logic                          last_result
);

	// The controller only sequences; all counters, stores and compares sit in the datapath.
	lms_pkg::lms_cmd_t  cmd;
	lms_pkg::lms_stat_t stat;

	lms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_job (last_job),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath registers every result field, so the result ports come straight from flops.
	lms_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.job_id        (job_id),
		.job_time      (job_time),
		.result_valid  (result_valid),
		.status        (status),
		.assigned_job  (assigned_job),
		.machine_index (machine_index),
		.start_time    (start_time),
		.end_time      (end_time),
		.last_result   (last_result)
	);

endmodule
